[src/swtf_pkg.sv]
`default_nettype none
package swtf_pkg;

   // g = 9.81 in Q16.16, rounded to nearest
   localparam logic [19:0] G_Q16 = 20'd642908;

   localparam int HCW       = 31;          // clamped height magnitude
   localparam int SQW       = 52;          // radicand g*h, Q32.32
   localparam int RTW       = 26;          // root, Q16.16
   localparam int SQ_STAGES = RTW;         // one root bit per stage
   localparam int CW        = 33;          // wave speed, unsigned
   localparam int AW        = 35;          // u +/- c, signed
   localparam int PW        = 64;          // h*v, signed Q32.32
   localparam int LOW       = 32;          // low partial-product operand width
   localparam int MLW       = AW + LOW + 1;
   localparam int MHW       = AW + PW - LOW;
   localparam int SW        = 100;         // exact 2*F * 2^48
   localparam int RSH       = 33;
   localparam int QW        = SW - RSH;

   typedef struct packed {
      logic                 dry;
      logic signed [31:0]   ul;
      logic signed [31:0]   ur;
      logic signed [PW-1:0] pl;
      logic signed [PW-1:0] pr;
   } carry_type;

endpackage
`default_nettype wire

[src/swtf_req_if.sv]
`default_nettype none
interface swtf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_normal_velocity;
   logic signed [31:0] right_normal_velocity;
   logic signed [31:0] left_transverse_velocity;
   logic signed [31:0] right_transverse_velocity;
   logic signed [31:0] left_height;
   logic signed [31:0] right_height;

   modport source (
      output valid, left_normal_velocity, right_normal_velocity,
             left_transverse_velocity, right_transverse_velocity,
             left_height, right_height,
      input  ready
   );
   modport sink (
      input  valid, left_normal_velocity, right_normal_velocity,
             left_transverse_velocity, right_transverse_velocity,
             left_height, right_height,
      output ready
   );
endinterface
`default_nettype wire

[src/swtf_rsp_if.sv]
`default_nettype none
interface swtf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] momentum_flux;
   logic               saturated;

   modport source (output valid, momentum_flux, saturated, input ready);
   modport sink   (input valid, momentum_flux, saturated, output ready);
endinterface
`default_nettype wire

[src/shallow_water_transverse_flux.sv]
// Transverse momentum Rusanov flux, fully pipelined.
// One interface per cycle unless stalled; the 26-stage root pipe sets the depth.
// A stalled response freezes the whole pipe; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; no clearing pass.
`default_nettype none
module shallow_water_transverse_flux (
   input  logic       clock,
   input  logic       reset,
   swtf_req_if.sink   req_ch,
   swtf_rsp_if.source rsp_ch
);
   import swtf_pkg::*;

   logic adv;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_flux_ff;
   logic rsp_sat_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // input register
   logic v1_ff;
   logic signed [31:0] ul1_ff, ur1_ff, vl1_ff, vr1_ff, hl1_ff, hr1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_ch.valid;
      if (adv) begin
         ul1_ff <= req_ch.left_normal_velocity;
         ur1_ff <= req_ch.right_normal_velocity;
         vl1_ff <= req_ch.left_transverse_velocity;
         vr1_ff <= req_ch.right_transverse_velocity;
         hl1_ff <= req_ch.left_height;
         hr1_ff <= req_ch.right_height;
      end
   end

   // products and radicands
   logic [HCW-1:0] hcl, hcr;
   carry_type c2_in;
   assign hcl = hl1_ff[31] ? '0 : hl1_ff[HCW-1:0];
   assign hcr = hr1_ff[31] ? '0 : hr1_ff[HCW-1:0];

   always_comb begin
      c2_in.dry = (hl1_ff <= 0) && (hr1_ff <= 0);
      c2_in.ul  = ul1_ff;
      c2_in.ur  = ur1_ff;
      c2_in.pl  = PW'(hl1_ff) * PW'(vl1_ff);
      c2_in.pr  = PW'(hr1_ff) * PW'(vr1_ff);
   end

   logic            sq_v_ff    [SQ_STAGES+1];
   carry_type       sq_c_ff    [SQ_STAGES+1];
   logic [SQW-1:0]  sq_reml_ff [SQ_STAGES+1];
   logic [SQW-1:0]  sq_remr_ff [SQ_STAGES+1];
   logic [RTW-1:0]  sq_rtl_ff  [SQ_STAGES+1];
   logic [RTW-1:0]  sq_rtr_ff  [SQ_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else if (adv) sq_v_ff[0] <= v1_ff;
      if (adv) begin
         sq_c_ff[0]    <= c2_in;
         sq_reml_ff[0] <= SQW'(G_Q16) * SQW'(hcl);
         sq_remr_ff[0] <= SQW'(G_Q16) * SQW'(hcr);
         sq_rtl_ff[0]  <= '0;
         sq_rtr_ff[0]  <= '0;
      end
   end

   // restoring square root, one result bit per stage, both sides in parallel
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      localparam int P = RTW - 1 - k;
      logic [SQW-1:0] trial_l, trial_r;
      logic take_l, take_r;
      assign trial_l = (SQW'(sq_rtl_ff[k]) << (P + 1)) + (SQW'(1) << (2 * P));
      assign trial_r = (SQW'(sq_rtr_ff[k]) << (P + 1)) + (SQW'(1) << (2 * P));
      assign take_l  = sq_reml_ff[k] >= trial_l;
      assign take_r  = sq_remr_ff[k] >= trial_r;

      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[k+1] <= 1'b0;
         else if (adv) sq_v_ff[k+1] <= sq_v_ff[k];
         if (adv) begin
            sq_c_ff[k+1]    <= sq_c_ff[k];
            sq_reml_ff[k+1] <= take_l ? sq_reml_ff[k] - trial_l : sq_reml_ff[k];
            sq_remr_ff[k+1] <= take_r ? sq_remr_ff[k] - trial_r : sq_remr_ff[k];
            sq_rtl_ff[k+1]  <= take_l ? sq_rtl_ff[k] | (RTW'(1) << P) : sq_rtl_ff[k];
            sq_rtr_ff[k+1]  <= take_r ? sq_rtr_ff[k] | (RTW'(1) << P) : sq_rtr_ff[k];
         end
      end
   end

   // wave speed
   localparam int N = SQ_STAGES;
   carry_type sq_out;
   logic [31:0] mag_l, mag_r;
   logic [CW-1:0] cl, cr;
   assign sq_out = sq_c_ff[N];
   assign mag_l  = sq_out.ul[31] ? (~sq_out.ul + 32'd1) : sq_out.ul;
   assign mag_r  = sq_out.ur[31] ? (~sq_out.ur + 32'd1) : sq_out.ur;
   assign cl     = CW'(mag_l) + CW'(sq_rtl_ff[N]);
   assign cr     = CW'(mag_r) + CW'(sq_rtr_ff[N]);

   logic vc_ff;
   carry_type cc_ff;
   logic [CW-1:0] c_ff;

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (adv) vc_ff <= sq_v_ff[N];
      if (adv) begin
         cc_ff <= sq_out;
         c_ff  <= (cl >= cr) ? cl : cr;
      end
   end

   // u + c and u - c
   logic va_ff;
   carry_type ca_ff;
   logic signed [AW-1:0] al_ff, ar_ff;
   logic signed [AW-1:0] c_ext;
   assign c_ext = $signed(AW'(c_ff));

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= vc_ff;
      if (adv) begin
         ca_ff <= cc_ff;
         al_ff <= AW'(cc_ff.ul) + c_ext;
         ar_ff <= AW'(cc_ff.ur) - c_ext;
      end
   end

   // partial products: (u +/- c) times low and high halves of h*v
   logic vm_ff, dry_m_ff;
   logic signed [MLW-1:0] mll_ff, mrl_ff;
   logic signed [MHW-1:0] mlh_ff, mrh_ff;
   logic signed [LOW:0] pl_lo, pr_lo;
   logic signed [PW-LOW-1:0] pl_hi, pr_hi;
   assign pl_lo = $signed({1'b0, ca_ff.pl[LOW-1:0]});
   assign pr_lo = $signed({1'b0, ca_ff.pr[LOW-1:0]});
   assign pl_hi = ca_ff.pl[PW-1:LOW];
   assign pr_hi = ca_ff.pr[PW-1:LOW];

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else if (adv) vm_ff <= va_ff;
      if (adv) begin
         dry_m_ff <= ca_ff.dry;
         mll_ff   <= MLW'(al_ff) * MLW'(pl_lo);
         mrl_ff   <= MLW'(ar_ff) * MLW'(pr_lo);
         mlh_ff   <= MHW'(al_ff) * MHW'(pl_hi);
         mrh_ff   <= MHW'(ar_ff) * MHW'(pr_hi);
      end
   end

   // recombine halves
   logic vj_ff, dry_j_ff;
   logic signed [SW-1:0] ml_ff, mr_ff;

   always_ff @(posedge clock) begin
      if (reset) vj_ff <= 1'b0;
      else if (adv) vj_ff <= vm_ff;
      if (adv) begin
         dry_j_ff <= dry_m_ff;
         ml_ff    <= (SW'(mlh_ff) <<< LOW) + SW'(mll_ff);
         mr_ff    <= (SW'(mrh_ff) <<< LOW) + SW'(mrl_ff);
      end
   end

   // sum with rounding offset
   logic vs_ff, dry_s_ff;
   logic signed [SW-1:0] s_ff;

   always_ff @(posedge clock) begin
      if (reset) vs_ff <= 1'b0;
      else if (adv) vs_ff <= vj_ff;
      if (adv) begin
         dry_s_ff <= dry_j_ff;
         s_ff     <= ml_ff + mr_ff + (SW'(1) <<< (RSH - 1));
      end
   end

   // scale down and saturate; dry cells give zero
   logic signed [QW-1:0] q;
   logic fits;
   assign q    = QW'(s_ff >>> RSH);
   assign fits = (q[QW-1:31] == '0) || (q[QW-1:31] == '1);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vs_ff;
      if (adv) begin
         if (dry_s_ff) begin
            rsp_flux_ff <= '0;
            rsp_sat_ff  <= 1'b0;
         end else if (fits) begin
            rsp_flux_ff <= q[31:0];
            rsp_sat_ff  <= 1'b0;
         end else begin
            rsp_flux_ff <= q[QW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            rsp_sat_ff  <= 1'b1;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.momentum_flux = rsp_flux_ff;
   assign rsp_ch.saturated     = rsp_sat_ff;

   // root is floor: remainder never exceeds 2*root
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[N] |-> ((sq_reml_ff[N] <= (SQW'(sq_rtl_ff[N]) << 1)) &&
                      (sq_remr_ff[N] <= (SQW'(sq_rtr_ff[N]) << 1))))
      else $error("square root remainder out of range");

   // both sides use the same wave speed
   a_same_speed: assert property (@(posedge clock) disable iff (reset)
      va_ff |-> ((al_ff - AW'(ca_ff.ul)) == (AW'(ca_ff.ur) - ar_ff)))
      else $error("left and right wave speeds differ");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         ((rsp_flux_ff == 32'sh7FFF_FFFF) || (rsp_flux_ff == 32'sh8000_0000)))
      else $error("saturated flag without clipped value");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && vs_ff) |=> (vs_ff && $stable(s_ff)))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire
